### design/mbea_pkg.sv
// ----------------------------------------------------------------------------
// mbea_pkg
// Shared types, constants and the CORDIC angle table for the multibrot
// escape-angle block.
// ----------------------------------------------------------------------------
`default_nettype none

package mbea_pkg;

  localparam int FRAC              = 28;
  localparam int CORDIC_STEPS      = 28;
  localparam int ANGLE_BITS_DEFAULT = 16;

  localparam logic [3:0]  DEGREE_RESET      = 4'd3;
  localparam logic [8:0]  ESCAPE_NORM_RESET = 9'd100;
  localparam logic [15:0] MAX_ITER_RESET    = 16'd50;

  typedef logic signed [63:0] fix_t;

  typedef enum logic [1:0] {
    CFG_DEGREE      = 2'd0,
    CFG_ESCAPE_NORM = 2'd1,
    CFG_MAX_ITER    = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    OPA_XRE,
    OPA_XIM,
    OPA_PRE,
    OPA_PIM
  } opa_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SQ_MUL,
    ST_SQ_FOLD,
    ST_SQ_ACC,
    ST_SQ_CMP,
    ST_PW_MUL,
    ST_PW_FOLD,
    ST_PW_ACC,
    ST_PW_UPD,
    ST_X_UPD,
    ST_CORDIC,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic       load;
    logic       mul;
    opa_sel_t   a_sel;
    logic       b_im;
    logic       fold;
    logic       acc;
    logic       acc_im;
    logic       acc_first;
    logic       acc_sub;
    logic       p_init;
    logic       p_upd;
    logic       x_upd;
    logic       cordic_init;
    logic       cordic_step;
    logic [4:0] cordic_k;
    logic       finish_esc;
    logic       finish_none;
  } dp_cmd_t;

  typedef struct packed {
    logic iter_done;
    logic oversize;
    logic below;
  } dp_status_t;

  // Arctangent of 2^-k in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] k);
    logic [31:0] v;
    case (k)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### design/mbea_ctrl.sv
// ----------------------------------------------------------------------------
// mbea_ctrl
// Sequencer: steps the datapath through the escape test, the complex power,
// the CORDIC and the final result.
// ----------------------------------------------------------------------------
`default_nettype none

module mbea_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [3:0]          degree_eff,
  input  wire mbea_pkg::dp_status_t status,
  output mbea_pkg::dp_cmd_t        cmd,
  output logic                     busy
);
  import mbea_pkg::*;

  state_t     state, state_next;
  logic [1:0] pidx, pidx_next;
  logic [2:0] j, j_next;
  logic [4:0] k, k_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pidx  <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      pidx  <= pidx_next;
      j     <= j_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next   = state;
    pidx_next    = pidx;
    j_next       = j;
    k_next       = k;
    cmd          = '0;
    cmd.a_sel    = OPA_XRE;
    cmd.cordic_k = k;
    busy         = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.iter_done) begin
          cmd.finish_none = 1'b1;
          state_next      = ST_IDLE;
        end else if (status.oversize) begin
          cmd.cordic_init = 1'b1;
          k_next          = '0;
          state_next      = ST_CORDIC;
        end else begin
          pidx_next  = '0;
          state_next = ST_SQ_MUL;
        end
      end
      ST_SQ_MUL: begin
        cmd.mul    = 1'b1;
        cmd.a_sel  = pidx[0] ? OPA_XIM : OPA_XRE;
        cmd.b_im   = pidx[0];
        state_next = ST_SQ_FOLD;
      end
      ST_SQ_FOLD: begin
        cmd.fold   = 1'b1;
        state_next = ST_SQ_ACC;
      end
      ST_SQ_ACC: begin
        cmd.acc       = 1'b1;
        cmd.acc_first = !pidx[0];
        if (pidx[0]) begin
          state_next = ST_SQ_CMP;
        end else begin
          pidx_next  = pidx + 2'd1;
          state_next = ST_SQ_MUL;
        end
      end
      ST_SQ_CMP: begin
        if (!status.below) begin
          cmd.cordic_init = 1'b1;
          k_next          = '0;
          state_next      = ST_CORDIC;
        end else begin
          cmd.p_init = 1'b1;
          j_next     = 3'd1;
          pidx_next  = '0;
          state_next = (degree_eff == 4'd1) ? ST_X_UPD : ST_PW_MUL;
        end
      end
      ST_PW_MUL: begin
        cmd.mul    = 1'b1;
        cmd.a_sel  = pidx[0] ? OPA_PIM : OPA_PRE;
        cmd.b_im   = pidx[0] ^ pidx[1];
        state_next = ST_PW_FOLD;
      end
      ST_PW_FOLD: begin
        cmd.fold   = 1'b1;
        state_next = ST_PW_ACC;
      end
      ST_PW_ACC: begin
        cmd.acc       = 1'b1;
        cmd.acc_im    = pidx[1];
        cmd.acc_first = !pidx[0];
        cmd.acc_sub   = (pidx == 2'd1);
        pidx_next     = pidx + 2'd1;
        state_next    = (pidx == 2'd3) ? ST_PW_UPD : ST_PW_MUL;
      end
      ST_PW_UPD: begin
        cmd.p_upd = 1'b1;
        pidx_next = '0;
        if (({1'b0, j} + 4'd1) == degree_eff) begin
          state_next = ST_X_UPD;
        end else begin
          j_next     = j + 3'd1;
          state_next = ST_PW_MUL;
        end
      end
      ST_X_UPD: begin
        cmd.x_upd  = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CORDIC: begin
        cmd.cordic_step = 1'b1;
        if (k == 5'(CORDIC_STEPS - 1)) begin
          state_next = ST_FINISH;
        end else begin
          k_next = k + 5'd1;
        end
      end
      ST_FINISH: begin
        cmd.finish_esc = 1'b1;
        state_next     = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### design/mbea_datapath.sv
// ----------------------------------------------------------------------------
// mbea_datapath
// Q35.28 iterate, shared 64x32 magnitude product built from two 32x32
// products, accumulators, CORDIC vectoring unit and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mbea_datapath #(
  parameter int ANGLE_BITS = mbea_pkg::ANGLE_BITS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire mbea_pkg::dp_cmd_t    cmd,
  input  wire logic signed [30:0]   c_re,
  input  wire logic signed [30:0]   c_im,
  input  wire logic [3:0]           degree_eff,
  input  wire logic [8:0]           escape_norm,
  input  wire logic [15:0]          max_iterations,
  output mbea_pkg::dp_status_t      status,
  output logic                      done,
  output logic signed [20:0]        escape_value
);
  import mbea_pkg::*;

  fix_t c_re_r, c_im_r, x_re, x_im, p_re, p_im, acc0, acc1, cx, cy;
  logic [63:0] prod_lo, prod_hi, m;
  logic        prod_neg, m_neg;
  logic [15:0] iter;
  logic signed [32:0] z;

  fix_t        a_op, b_op, acc_base, acc_sum;
  logic [63:0] a_mag, b_full_mag, xre_mag, xim_mag;
  logic [95:0] full;
  logic [8:0]  r_eff;
  fix_t        thr;
  logic        eff_neg;
  fix_t        dx, dy;
  logic [32:0] atan_ext;
  logic [30:0] q;
  logic [31:0] q32, phi;
  logic [ANGLE_BITS-1:0] t;
  logic [ANGLE_BITS+3:0] td;
  logic [19:0] id;

  always_comb begin
    case (cmd.a_sel)
      OPA_XRE: a_op = x_re;
      OPA_XIM: a_op = x_im;
      OPA_PRE: a_op = p_re;
      OPA_PIM: a_op = p_im;
      default: a_op = x_re;
    endcase
    b_op       = cmd.b_im ? x_im : x_re;
    a_mag      = a_op[63] ? 64'(-a_op) : 64'(a_op);
    b_full_mag = b_op[63] ? 64'(-b_op) : 64'(b_op);
    xre_mag    = x_re[63] ? 64'(-x_re) : 64'(x_re);
    xim_mag    = x_im[63] ? 64'(-x_im) : 64'(x_im);
    full       = {32'd0, prod_lo} + {prod_hi, 32'd0};
    eff_neg    = m_neg ^ cmd.acc_sub;
    acc_base   = cmd.acc_first ? fix_t'(0) : (cmd.acc_im ? acc1 : acc0);
    acc_sum    = eff_neg ? (acc_base - fix_t'(m)) : (acc_base + fix_t'(m));
    r_eff      = (escape_norm > 9'd256) ? 9'd256 : escape_norm;
    thr        = fix_t'({27'd0, r_eff, 28'd0});
    dx         = cy >>> cmd.cordic_k;
    dy         = cx >>> cmd.cordic_k;
    atan_ext   = {1'b0, atan_turn(cmd.cordic_k)};
    if (z[32]) begin
      q = '0;
    end else if (z > 33'sd1073741824) begin
      q = 31'd1073741824;
    end else begin
      q = z[30:0];
    end
    q32 = {1'b0, q};
    case ({x_re[63], x_im[63]})
      2'b00:   phi = q32;
      2'b01:   phi = 32'd0 - q32;
      2'b10:   phi = 32'h8000_0000 - q32;
      default: phi = 32'h8000_0000 + q32;
    endcase
    t  = phi[31 -: ANGLE_BITS];
    td = t * degree_eff;
    id = iter * degree_eff;
  end

  assign status.iter_done = (iter >= max_iterations);
  assign status.oversize  = (xre_mag[63:32] != 32'd0) || (xim_mag[63:32] != 32'd0);
  assign status.below     = (acc0 < thr);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_re_r <= fix_t'(c_re);
      c_im_r <= fix_t'(c_im);
      x_re   <= fix_t'(c_re);
      x_im   <= fix_t'(c_im);
      iter   <= '0;
    end
    if (cmd.mul) begin
      prod_lo  <= a_mag[31:0] * b_full_mag[31:0];
      prod_hi  <= a_mag[63:32] * b_full_mag[31:0];
      prod_neg <= a_op[63] ^ b_op[63];
    end
    if (cmd.fold) begin
      m     <= full[91:28];
      m_neg <= prod_neg;
    end
    if (cmd.acc) begin
      if (cmd.acc_im) begin
        acc1 <= acc_sum;
      end else begin
        acc0 <= acc_sum;
      end
    end
    if (cmd.p_init) begin
      p_re <= x_re;
      p_im <= x_im;
    end
    if (cmd.p_upd) begin
      p_re <= acc0;
      p_im <= acc1;
    end
    if (cmd.x_upd) begin
      x_re <= p_re + c_re_r;
      x_im <= p_im + c_im_r;
      iter <= iter + 16'd1;
    end
    if (cmd.cordic_init) begin
      cx <= fix_t'({3'd0, xre_mag[63:3]});
      cy <= fix_t'({3'd0, xim_mag[63:3]});
      z  <= '0;
    end
    if (cmd.cordic_step) begin
      if (!cy[63]) begin
        cx <= cx + dx;
        cy <= cy - dy;
        z  <= z + $signed(atan_ext);
      end else begin
        cx <= cx - dx;
        cy <= cy + dy;
        z  <= z - $signed(atan_ext);
      end
    end
    if (cmd.finish_esc) begin
      escape_value <= $signed({1'b0, id} + {17'd0, td[ANGLE_BITS+3:ANGLE_BITS]});
    end
    if (cmd.finish_none) begin
      escape_value <= '1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish_esc | cmd.finish_none;
    end
  end

endmodule

`default_nettype wire

### design/multibrot_escape_angle.sv
// ----------------------------------------------------------------------------
// multibrot_escape_angle
// Escape time of x -> x^d + c with the external angle of the escaping
// iterate folded in as a fraction of the count.
// ----------------------------------------------------------------------------
// A point c (c_re, c_im, signed Q2.28) is taken on a cycle where start is
// high and busy is low; the block then stays busy until the cycle in which
// its one result is shown, and a new point may be taken in that cycle. The
// result appears on escape_value for exactly one cycle with done high, and
// it is a transfer whether or not anyone looks: the receiver cannot stall
// the block, so it must capture the value in that cycle. The result is -1
// when the iteration limit is reached, otherwise floor((i + T) * d), where i
// is the iteration count at escape and T the angle of the final iterate as
// an ANGLE_BITS-bit fraction of a turn. Every real product goes through a
// single magnitude multiplier built from two 32x32 products, in the steps
// multiply, fold and accumulate, and this unit sets the pace. The squared
// magnitude is skipped when a part of the iterate has reached 16. A degree
// of zero behaves as one and degrees above eight as eight; an escape
// threshold above 256 behaves as 256. Configuration writes take effect at
// once and should only be made while the block is not busy.
// ----------------------------------------------------------------------------
`default_nettype none

module multibrot_escape_angle #(
  parameter int ANGLE_BITS = mbea_pkg::ANGLE_BITS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [30:0] c_re,
  input  wire logic signed [30:0] c_im,
  output logic                    done,
  output logic signed [20:0]      escape_value,
  input  wire logic               cfg_write,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import mbea_pkg::*;

  logic [3:0]  degree;
  logic [8:0]  escape_norm;
  logic [15:0] max_iterations;
  logic [3:0]  degree_eff;
  dp_cmd_t     cmd;
  dp_status_t  status;

  // Configuration registers; a write to the unused index is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      degree         <= DEGREE_RESET;
      escape_norm    <= ESCAPE_NORM_RESET;
      max_iterations <= MAX_ITER_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DEGREE:      degree         <= cfg_data[3:0];
        CFG_ESCAPE_NORM: escape_norm    <= cfg_data[8:0];
        CFG_MAX_ITER:    max_iterations <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // The exponent is held to the range one to eight.
  always_comb begin
    if (degree == 4'd0) begin
      degree_eff = 4'd1;
    end else if (degree > 4'd8) begin
      degree_eff = 4'd8;
    end else begin
      degree_eff = degree;
    end
  end

  mbea_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .degree_eff (degree_eff),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy)
  );

  mbea_datapath #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .c_re           (c_re),
    .c_im           (c_im),
    .degree_eff     (degree_eff),
    .escape_norm    (escape_norm),
    .max_iterations (max_iterations),
    .status         (status),
    .done           (done),
    .escape_value   (escape_value)
  );

  // An accepted point always makes the block busy on the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted point did not make the block busy");

  // A result only follows a busy cycle.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result shown without a point in progress");

  // One point gives exactly one result, never two in a row.
  a_single_result: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

endmodule

`default_nettype wire
